// ===== hw/rtl/double_ended_queue_core_macros.svh =====
// assertion helpers for the deque core
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// property checked at every clock edge outside reset
`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

    localparam int DATA_W = 64;
    localparam int POS_W  = 10;
    localparam int OCC_W  = 11;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_READ_FRONT = 3'd2,
        OP_READ_BACK  = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_POP_BACK   = 3'd5,
        OP_READ_INDEX = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic    wr_en;
        logic    rd_en;
        status_t status;
    } req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/deq_store.sv =====
`default_nettype none

module deq_store
    import deq_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [AW-1:0]     addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] q
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem[addr];
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/deq_ctrl.sv =====
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int CW    = 11
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [2:0]       op,
    input  wire logic [POS_W-1:0] position,
    output req_t                  req,
    output logic      [AW-1:0]    addr,
    output logic      [CW-1:0]    count_next
);

    localparam int OW = (CW > POS_W) ? CW : POS_W;
    localparam int SW = OW + 1;

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [CW-1:0] count_reg;
    logic          full;
    logic          empty;
    logic [OW-1:0] offset;
    logic [OW-1:0] pos_ext;
    logic [OW-1:0] cnt_ext;
    logic [SW-1:0] sum;
    logic [SW-1:0] wrapped;
    logic          direct;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign pos_ext  = OW'(position);
    assign cnt_ext  = OW'(count_reg);
    assign sum      = SW'(head_reg) + SW'(offset);
    assign wrapped  = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
    assign addr     = direct ? head_dec : wrapped[AW-1:0];

    always_comb
    begin
        req        = '0;
        req.status = ST_OK;
        offset     = '0;
        direct     = 1'b0;
        head_next  = head_reg;
        count_next = count_reg;
        unique case (op_t'(op))
            OP_PUSH_BACK:
            begin
                offset = cnt_ext;
                if (full)
                begin
                    req.status = ST_FULL;
                end
                else
                begin
                    req.wr_en  = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                direct = 1'b1;
                if (full)
                begin
                    req.status = ST_FULL;
                end
                else
                begin
                    req.wr_en  = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_READ_FRONT:
            begin
                if (empty)
                begin
                    req.status = ST_EMPTY;
                end
                else
                begin
                    req.rd_en = 1'b1;
                end
            end
            OP_READ_BACK:
            begin
                offset = cnt_ext - OW'(1);
                if (empty)
                begin
                    req.status = ST_EMPTY;
                end
                else
                begin
                    req.rd_en = 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    req.status = ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    req.status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            OP_READ_INDEX:
            begin
                offset = pos_ext;
                if (pos_ext >= cnt_ext)
                begin
                    req.status = ST_RANGE;
                end
                else
                begin
                    req.rd_en = 1'b1;
                end
            end
            default:
            begin
                req.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue_core.sv =====
// the result strobe done rises in the cycle right after start is taken
// throughput: one request per cycle, set by the single store port; busy stays low
// each request is at most one head/count update and at most one store read or write
// reset clears the head pointer and element count; store contents are not cleared
// and are only read at occupied slots
`default_nettype none
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [2:0]               op,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic [POS_W-1:0]         position,
    output logic                          done,
    output logic signed [DATA_W-1:0]      data,
    output logic [1:0]                    status,
    output logic [OCC_W-1:0]              occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > OCC_W) ? CW : OCC_W;

    logic              accept;
    req_t              req;
    logic [AW-1:0]     addr;
    logic [CW-1:0]     count_next;
    logic [EW-1:0]     count_ext;
    logic [DATA_W-1:0] q;
    logic              done_reg;
    logic              rd_reg;
    status_t           status_reg;
    logic [OCC_W-1:0]  occ_reg;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign count_ext = EW'(count_next);

    deq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (op),
        .position   (position),
        .req        (req),
        .addr       (addr),
        .count_next (count_next)
    );

    deq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (accept && req.wr_en),
        .re    (accept && req.rd_en),
        .addr  (addr),
        .wdata (value),
        .q     (q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            rd_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            rd_reg   <= accept && req.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= req.status;
            occ_reg    <= count_ext[OCC_W-1:0];
        end
    end

    assign done      = done_reg;
    assign data      = rd_reg ? q : '0;
    assign status    = status_reg;
    assign occupancy = occ_reg;

    `DEQ_ASSERT_NEXT(a_done_follows, clk, rst_n, accept, done, "transfer without result")
    `DEQ_ASSERT_NEXT(a_no_spurious, clk, rst_n, !accept, !done, "result without transfer")
    `DEQ_ASSERT(a_count_bound, clk, rst_n, !accept || (count_next <= CW'(DEPTH)), "count overflow")
    `DEQ_ASSERT(a_data_zero, clk, rst_n, !(done && status_reg != ST_OK) || (data == '0), "data on fail")

endmodule

`default_nettype wire

// ===== tb/tb_double_ended_queue_core.sv =====
`timescale 1ns / 100ps

module tb_double_ended_queue_core;
    import deq_pkg::*;

    localparam int DEPTH = 1024;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic signed [DATA_W-1:0] MAX_WORD = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_WORD = 64'sh8000_0000_0000_0000;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } deque_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [2:0]               op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic                     done;
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;

    // shadow deque
    logic [DATA_W-1:0] shadow_words [DEPTH];
    logic [POS_W-1:0]  shadow_head;
    int                shadow_count;

    deque_result_t expected_results [$];
    int            error_count;
    int            sender_idle_pct;
    int            stall_cycles;

    double_ended_queue_core #(
        .DEPTH (DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .value     (value),
        .position  (position),
        .done      (done),
        .data      (data),
        .status    (status),
        .occupancy (occupancy)
    );

    always #10 clk = ~clk;

    function automatic deque_result_t apply_request(input logic [2:0] req_op,
                                                    input logic signed [DATA_W-1:0] req_value,
                                                    input logic [POS_W-1:0] req_pos);
        deque_result_t res;
        res.data   = '0;
        res.status = ST_OK;
        case (req_op)
            OP_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    shadow_words[POS_W'(shadow_head + shadow_count)] = req_value;
                    shadow_count++;
                end
            end
            OP_PUSH_FRONT:
            begin
                if (shadow_count >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_words[shadow_head] = req_value;
                    shadow_count++;
                end
            end
            OP_READ_FRONT:
            begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else
                    res.data = shadow_words[shadow_head];
            end
            OP_READ_BACK:
            begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else
                    res.data = shadow_words[POS_W'(shadow_head + shadow_count - 1)];
            end
            OP_POP_FRONT:
            begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    shadow_head = shadow_head + 1'b1;
                    shadow_count--;
                end
            end
            OP_POP_BACK:
            begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else
                    shadow_count--;
            end
            OP_READ_INDEX:
            begin
                if (int'(req_pos) >= shadow_count)
                    res.status = ST_RANGE;
                else
                    res.data = shadow_words[POS_W'(shadow_head + req_pos)];
            end
            default:
            begin
            end
        endcase
        res.occupancy = OCC_W'(shadow_count);
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(15))
            0: return MAX_WORD;
            1: return MIN_WORD;
            2: return '0;
            3: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_request(input logic [2:0] req_op,
                                input logic signed [DATA_W-1:0] req_value,
                                input logic [POS_W-1:0] req_pos);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        op       <= req_op;
        value    <= req_value;
        position <= req_pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.insert(expected_results.size(),
                                apply_request(req_op, req_value, req_pos));
    endtask

    task automatic send_random(input int push_pct, input int pop_pct);
        int               pick;
        logic [2:0]       req_op;
        logic [POS_W-1:0] req_pos;
        pick = $urandom_range(99);
        if (pick < push_pct)
            req_op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else if (pick < push_pct + pop_pct)
            req_op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
        else if (pick < 98)
        begin
            case ($urandom_range(3))
                0: req_op = OP_READ_FRONT;
                1: req_op = OP_READ_BACK;
                default: req_op = OP_READ_INDEX;
            endcase
        end
        else
            req_op = OP_UNUSED;
        // mostly in-range or just past the end, sometimes anywhere
        if ($urandom_range(3) != 0)
            req_pos = POS_W'($urandom_range(shadow_count > DEPTH - 1 ? DEPTH - 1 : shadow_count));
        else
            req_pos = POS_W'($urandom);
        send_request(req_op, random_word(), req_pos);
    endtask

    task automatic test_directed();
        int k;
        sender_idle_pct = 15;
        send_request(OP_READ_FRONT, MAX_WORD, '1);
        send_request(OP_READ_BACK, MIN_WORD, '0);
        send_request(OP_POP_FRONT, '1, '1);
        send_request(OP_POP_BACK, '1, '0);
        send_request(OP_READ_INDEX, '0, '0);
        send_request(OP_UNUSED, '1, '1);
        send_request(OP_PUSH_BACK, MAX_WORD, '0);
        send_request(OP_PUSH_FRONT, MIN_WORD, '1);
        send_request(OP_PUSH_BACK, '1, 10'h155);
        send_request(OP_PUSH_FRONT, '0, 10'h2AA);
        send_request(OP_READ_FRONT, '0, '0);
        send_request(OP_READ_BACK, '0, '0);
        for (k = 0; k < 4; k++)
            send_request(OP_READ_INDEX, 64'h5555_5555_5555_5555, POS_W'(k));
        send_request(OP_READ_INDEX, 64'hAAAA_AAAA_AAAA_AAAA, 10'd4);
        send_request(OP_READ_INDEX, '0, '1);
        send_request(OP_UNUSED, '0, '0);
        send_request(OP_POP_FRONT, '0, '0);
        send_request(OP_POP_BACK, '0, '0);
        send_request(OP_READ_FRONT, '0, '0);
        send_request(OP_READ_BACK, '0, '0);
        send_request(OP_POP_FRONT, '0, '0);
        send_request(OP_POP_BACK, '0, '0);
        send_request(OP_POP_BACK, '0, '0);
    endtask

    task automatic test_mixed_traffic();
        sender_idle_pct = 15;
        repeat (150)
            send_random(55, 25);
    endtask

    task automatic test_fill_to_full();
        sender_idle_pct = 71;
        while (shadow_count < DEPTH)
            send_random(95, 0);
        // pushes into a full store get dropped
        repeat (12)
            send_random(60, 0);
    endtask

    task automatic test_drain();
        sender_idle_pct = 0;
        repeat (600)
            send_random(10, 80);
    endtask

    always @(posedge clk)
    begin
        deque_result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                error_count++;
            end
            else
            begin
                exp_res = expected_results[0];
                expected_results.delete(0);
                if (data !== exp_res.data)
                begin
                    $error("data: expected %h, got %h", exp_res.data, data);
                    error_count++;
                end
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, status);
                    error_count++;
                end
                if (occupancy !== exp_res.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", exp_res.occupancy, occupancy);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = '0;
        value        = '0;
        position     = '0;
        shadow_head  = '0;
        shadow_count = 0;
        error_count  = 0;
        stall_cycles = 0;
        sender_idle_pct = 0;
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_mixed_traffic();
        test_fill_to_full();
        test_drain();

        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/deq_store.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue_core.sv
tb/tb_double_ended_queue_core.sv
